[rtl/sha_pkg.sv]
// Shared types, constants and round functions for the SHA-256 stream hasher.
package sha_pkg;

    localparam int QueueDepth = 4;

    // Front-to-back command: one byte or an end-of-message marker.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       is_last;
    } sha_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_UPDATE,
        ST_PAD,
        ST_EMIT
    } sha_state_t;

    function automatic logic [31:0] round_const(input logic [5:0] idx);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,
            32'h3956c25b,32'h59f111f1,32'h923f82a4,32'hab1c5ed5,
            32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
            32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,
            32'he49b69c1,32'hefbe4786,32'h0fc19dc6,32'h240ca1cc,
            32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
            32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,
            32'hc6e00bf3,32'hd5a79147,32'h06ca6351,32'h14292967,
            32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
            32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,
            32'ha2bfe8a1,32'ha81a664b,32'hc24b8b70,32'hc76c51a3,
            32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
            32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,
            32'h391c0cb3,32'h4ed8aa4a,32'h5b9cca4f,32'h682e6ff3,
            32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
            32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
        return k[idx];
    endfunction

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] h [8];
        h = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
              32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
        return h[idx];
    endfunction

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

[rtl/sha_front.sv]
// Input side: accepts stream requests and queues them for the hashing engine.
module sha_front
    import sha_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  sha_cmd_t        in_cmd,
    output logic            cmd_valid,
    input  logic            cmd_take,
    output sha_cmd_t        cmd
);
    localparam int AW = $clog2(QueueDepth);

    sha_cmd_t        mem_reg [QueueDepth];
    logic [AW-1:0]   wptr_reg, rptr_reg;
    logic [AW:0]     count_reg;
    logic            push, pop;

    // Idle items carry nothing and are dropped here.
    assign in_ready  = (count_reg != (AW+1)'(QueueDepth));
    assign push      = in_valid && in_ready && (in_cmd.has_byte || in_cmd.is_last);
    assign cmd_valid = (count_reg != '0);
    assign pop       = cmd_valid && cmd_take;
    assign cmd       = mem_reg[rptr_reg];

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= in_cmd;
        end
    end

    // Queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push) wptr_reg <= wptr_reg + 1'b1;
            if (pop)  rptr_reg <= rptr_reg + 1'b1;
            count_reg <= count_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

[rtl/sha_engine.sv]
// Back side: block shift register, message schedule, 64-round compression and digest output.
module sha_engine
    import sha_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_take,
    input  sha_cmd_t        cmd,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [63:0]     digest_word,
    output logic [1:0]      word_index,
    output logic            last_word
);
    sha_state_t   state_reg, state_next;
    logic [6:0]   fill_reg;       // bytes shifted into the current block
    logic [63:0]  bits_reg;
    logic [31:0]  h_reg [8];
    logic [31:0]  v_reg [8];
    logic [31:0]  w_reg [16];     // block bytes while filling, schedule window while rounding
    logic [5:0]   rnd_reg;
    logic         pad_reg;        // the 0x80 marker has been placed
    logic         final_reg;      // the block being padded carries the length
    logic         second_reg;     // a second padding block follows
    logic         pend_last_reg;  // end marker rode with the byte that filled a block
    logic [1:0]   widx_reg;

    // Byte shift into the block.
    logic         wr_byte;
    logic         shift_en;
    logic [7:0]   shift_byte;

    // Round logic on the working variables.
    logic [31:0] t1, t2, s0, s1, ch, maj, ws0, ws1, w_new;
    always_comb
    begin
        s1  = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1  = v_reg[7] + s1 + ch + round_const(rnd_reg) + w_reg[0];
        s0  = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2  = s0 + maj;
        ws0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        ws1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + ws0 + w_reg[9] + ws1;
    end

    // Byte entering the block: payload, or one padding byte per cycle.
    assign shift_en = wr_byte || (state_reg == ST_PAD);
    always_comb
    begin
        if (state_reg == ST_PAD)
        begin
            if (!pad_reg)
                shift_byte = PAD_BYTE;
            else if (final_reg && fill_reg >= 7'd56)
                shift_byte = bits_reg[{~fill_reg[2:0], 3'b000} +: 8];
            else
                shift_byte = 8'h00;
        end
        else
        begin
            shift_byte = cmd.data_byte;
        end
    end

    // Next state and handshake outputs.
    always_comb
    begin
        state_next = state_reg;
        cmd_take   = 1'b0;
        wr_byte    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take = 1'b1;
                    wr_byte  = cmd.has_byte;
                    if (cmd.has_byte && fill_reg == 7'd63)
                        state_next = ST_LOAD;
                    else if (cmd.is_last)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:    if (fill_reg == 7'd63) state_next = ST_LOAD;
            ST_LOAD:   state_next = ST_ROUND;
            ST_ROUND:  if (rnd_reg == 6'd63) state_next = ST_UPDATE;
            ST_UPDATE:
            begin
                if (second_reg)         state_next = ST_PAD;
                else if (final_reg)     state_next = ST_EMIT;
                else if (pend_last_reg) state_next = ST_PAD;
                else                    state_next = ST_IDLE;
            end
            ST_EMIT:   if (out_ready && widx_reg == 2'd3) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    assign out_valid   = (state_reg == ST_EMIT);
    assign digest_word = {h_reg[{widx_reg, 1'b0}], h_reg[{widx_reg, 1'b1}]};
    assign word_index  = widx_reg;
    assign last_word   = (widx_reg == 2'd3);

    // Block bytes shift in big-endian; the rounds then shift the window by words.
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= {w_reg[i][23:0], w_reg[i+1][31:24]};
            w_reg[15] <= {w_reg[15][23:0], shift_byte};
        end
        else if (state_reg == ST_LOAD)
        begin
            for (int i = 0; i < 8; i++)
                v_reg[i] <= h_reg[i];
        end
        else if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    // Control and chaining state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            bits_reg      <= '0;
            rnd_reg       <= '0;
            pad_reg       <= 1'b0;
            final_reg     <= 1'b0;
            second_reg    <= 1'b0;
            pend_last_reg <= 1'b0;
            widx_reg      <= '0;
            for (int i = 0; i < 8; i++) h_reg[i] <= init_hash(3'(i));
        end
        else
        begin
            state_reg <= state_next;
            if (shift_en)
                fill_reg <= fill_reg + 7'd1;
            if (wr_byte && fill_reg == 7'd63)
                pend_last_reg <= cmd.is_last;
            if (state_reg == ST_LOAD) rnd_reg <= '0;
            if (state_reg == ST_ROUND) rnd_reg <= rnd_reg + 6'd1;
            // The first padding cycle fixes the message length and the block count.
            if (state_reg == ST_PAD)
            begin
                pend_last_reg <= 1'b0;
                if (!pad_reg)
                begin
                    pad_reg    <= 1'b1;
                    bits_reg   <= bits_reg + {55'd0, fill_reg[5:0], 3'd0};
                    final_reg  <= (fill_reg < 7'd56);
                    second_reg <= (fill_reg >= 7'd56);
                end
            end
            if (state_reg == ST_UPDATE)
            begin
                for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
                fill_reg <= '0;
                if (!pad_reg)
                    bits_reg <= bits_reg + 64'd512;
                if (second_reg)
                begin
                    second_reg <= 1'b0;
                    final_reg  <= 1'b1;
                end
            end
            if (state_reg == ST_EMIT && out_ready)
            begin
                widx_reg <= widx_reg + 2'd1;
                if (widx_reg == 2'd3)
                begin
                    for (int i = 0; i < 8; i++) h_reg[i] <= init_hash(3'(i));
                    bits_reg  <= '0;
                    pad_reg   <= 1'b0;
                    final_reg <= 1'b0;
                end
            end
        end
    end
endmodule

[rtl/sha256_stream_hasher.sv]
// Top level of the SHA-256 stream hasher.
// A message enters one byte per request on the slave side; an item with the
// last flag ends it, and an item with no byte may end an empty message. A
// small queue takes up to four requests while the engine is busy. Bytes go
// into the block one per cycle while it fills; each full 64-byte block is
// then compressed in the single round unit, and the engine takes no bytes
// from the queue until it is done. At the end of a message the padding bytes
// are shifted in one per cycle and the partial block is compressed; a second
// padding block is needed when 56 or more bytes are left over. The digest then
// leaves as four 64-bit big-endian words on the master side, word 0 first,
// one per cycle while the sink is ready.
module sha256_stream_hasher
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // has_byte
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // digest_word
    output logic [1:0]  m_tuser,   // word_index
    output logic        m_tlast    // last_word
);
    sha_cmd_t in_cmd, cmd;
    logic     cmd_valid, cmd_take;

    assign in_cmd = '{data_byte: s_tdata, has_byte: s_tuser, is_last: s_tlast};

    sha_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_cmd(in_cmd),
        .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
    );

    sha_engine u_engine (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .digest_word(m_tdata), .word_index(m_tuser), .last_word(m_tlast)
    );
endmodule
